// ----- design/fmp_pkg.sv -----
// Shared constants and types for the Fibonacci-modulo-Pisano unit.
// No dependencies; used by the interfaces, controller, datapath and top level.
package fmp_pkg;

  localparam int MOD_BITS = 16;                 // modulus bits actually used
  localparam int IDX_W    = 63;                 // index field width
  localparam int MOD_IN_W = 16;                 // modulus field width
  localparam int RES_W    = 16;                 // residue field width
  localparam int PER_W    = MOD_BITS + 3;       // holds 6*m, the period bound
  localparam int DIVC_W   = $clog2(IDX_W + 1);  // serial divider bit counter

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture an input transaction, seed the pair
    logic per_step;   // one period-search step
    logic div_step;   // one bit of n mod period
    logic fib_step;   // one recurrence step, count down
    logic res_load;   // move the answer into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic m_small;    // modulus below two, answer is zero
    logic per_end;    // this search step finishes the period or reaches the bound
    logic div_last;   // this is the last division bit
    logic k_zero;     // reduced index count has run out
    logic out_free;   // output register can take a result this cycle
  } sts_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SETUP  = 6'b000010,
    S_PERIOD = 6'b000100,
    S_DIV    = 6'b001000,
    S_FIB    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

endpackage

// ----- design/fmp_if.sv -----
// Valid/ready channel interfaces for the Fibonacci-modulo-Pisano unit.
// Depends on fmp_pkg for the field widths.
interface fmp_in_if;
  logic                          valid;
  logic                          ready;
  logic [fmp_pkg::IDX_W-1:0]     index_n;
  logic [fmp_pkg::MOD_IN_W-1:0]  modulus;

  modport source (output valid, output index_n, output modulus, input ready);
  modport sink   (input valid, input index_n, input modulus, output ready);
endinterface

interface fmp_out_if;
  logic                       valid;
  logic                       ready;
  logic [fmp_pkg::RES_W-1:0]  residue;

  modport source (output valid, output residue, input ready);
  modport sink   (input valid, input residue, output ready);
endinterface

// ----- design/fmp_ctrl.sv -----
// Sequencing state machine for the Fibonacci-modulo-Pisano unit.
// Depends on fmp_pkg; drives fmp_dp through cmd_t, reads sts_t.
module fmp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  fmp_pkg::sts_t  sts,
  output fmp_pkg::cmd_t  cmd
);

  fmp_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      fmp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = fmp_pkg::S_SETUP;
        end
      end
      fmp_pkg::S_SETUP: begin
        state_nxt = sts.m_small ? fmp_pkg::S_DONE : fmp_pkg::S_PERIOD;
      end
      fmp_pkg::S_PERIOD: begin
        cmd.per_step = 1'b1;
        if (sts.per_end) state_nxt = fmp_pkg::S_DIV;
      end
      fmp_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = fmp_pkg::S_FIB;
      end
      fmp_pkg::S_FIB: begin
        if (sts.k_zero) state_nxt = fmp_pkg::S_DONE;
        else            cmd.fib_step = 1'b1;
      end
      fmp_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = fmp_pkg::S_IDLE;
        end
      end
      default: state_nxt = fmp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= fmp_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // Only one datapath operation per cycle.
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.per_step, cmd.div_step, cmd.fib_step, cmd.res_load}))
    else $error("fmp_ctrl: overlapping datapath commands");

  // A small modulus never enters the period search.
  a_small_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fmp_pkg::S_SETUP && sts.m_small) |=> state_r == fmp_pkg::S_DONE)
    else $error("fmp_ctrl: small modulus not short-cut");

  // After the last division bit the recurrence stage follows.
  a_div_to_fib: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && sts.div_last) |=> state_r == fmp_pkg::S_FIB)
    else $error("fmp_ctrl: division end missed");

endmodule

// ----- design/fmp_dp.sv -----
// Datapath of the Fibonacci-modulo-Pisano unit: pair registers, period
// counter, serial divider and output register. Depends on fmp_pkg.
module fmp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fmp_pkg::cmd_t                 cmd,
  output fmp_pkg::sts_t                 sts,
  input  logic [fmp_pkg::IDX_W-1:0]     in_index_n,
  input  logic [fmp_pkg::MOD_IN_W-1:0]  in_modulus,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fmp_pkg::RES_W-1:0]     out_residue
);

  logic [fmp_pkg::MOD_BITS-1:0] m_r, m_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [fmp_pkg::MOD_BITS-1:0] mod_in, sum_mod;
  logic [fmp_pkg::MOD_BITS:0]   sum;
  logic [fmp_pkg::PER_W-1:0]    cnt_r, cnt_nxt, bound_r, bound_nxt, rem_r, rem_nxt;
  logic [fmp_pkg::PER_W-1:0]    cnt_inc;
  logic [fmp_pkg::PER_W:0]      rem_sh;
  logic [fmp_pkg::IDX_W-1:0]    n_r, n_nxt;
  logic [fmp_pkg::DIVC_W-1:0]   bit_r, bit_nxt;
  logic [fmp_pkg::RES_W-1:0]    res_r, res_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // Modular add by one conditional subtraction.
  assign sum     = {1'b0, lo_r} + {1'b0, hi_r};
  assign sum_mod = (sum >= {1'b0, m_r}) ? fmp_pkg::MOD_BITS'(sum - {1'b0, m_r})
                                        : fmp_pkg::MOD_BITS'(sum);
  assign cnt_inc = cnt_r + fmp_pkg::PER_W'(1);
  assign mod_in  = fmp_pkg::MOD_BITS'(in_modulus);
  // Restoring division, one quotient bit per cycle.
  assign rem_sh  = {rem_r, n_r[fmp_pkg::IDX_W-1]};

  always_comb begin
    sts.m_small  = (m_r < fmp_pkg::MOD_BITS'(2));
    sts.per_end  = (hi_r == '0 && sum_mod == fmp_pkg::MOD_BITS'(1)) || (cnt_inc >= bound_r);
    sts.div_last = (bit_r == fmp_pkg::DIVC_W'(1));
    sts.k_zero   = (rem_r == '0);
    sts.out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    m_nxt         = m_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cnt_nxt       = cnt_r;
    bound_nxt     = bound_r;
    rem_nxt       = rem_r;
    n_nxt         = n_r;
    bit_nxt       = bit_r;
    res_nxt       = res_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (cmd.load) begin
      m_nxt     = mod_in;
      lo_nxt    = '0;
      hi_nxt    = fmp_pkg::MOD_BITS'(1);
      cnt_nxt   = '0;
      bound_nxt = fmp_pkg::PER_W'({mod_in, 2'b00}) + fmp_pkg::PER_W'({mod_in, 1'b0});
      rem_nxt   = '0;
      n_nxt     = in_index_n;
      bit_nxt   = fmp_pkg::DIVC_W'(fmp_pkg::IDX_W);
    end
    if (cmd.per_step || cmd.fib_step) begin
      lo_nxt = hi_r;
      hi_nxt = sum_mod;
    end
    if (cmd.per_step) cnt_nxt = cnt_inc;
    if (cmd.div_step) begin
      rem_nxt = (rem_sh >= {1'b0, cnt_r}) ? fmp_pkg::PER_W'(rem_sh - {1'b0, cnt_r})
                                          : fmp_pkg::PER_W'(rem_sh);
      n_nxt   = {n_r[fmp_pkg::IDX_W-2:0], 1'b0};
      bit_nxt = bit_r - fmp_pkg::DIVC_W'(1);
      // reseed the pair for the recurrence
      lo_nxt  = '0;
      hi_nxt  = fmp_pkg::MOD_BITS'(1);
    end
    if (cmd.fib_step) rem_nxt = rem_r - fmp_pkg::PER_W'(1);
    if (cmd.res_load) begin
      res_nxt       = sts.m_small ? '0 : fmp_pkg::RES_W'(lo_r);
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    m_r     <= m_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    cnt_r   <= cnt_nxt;
    bound_r <= bound_nxt;
    rem_r   <= rem_nxt;
    n_r     <= n_nxt;
    bit_r   <= bit_nxt;
    res_r   <= res_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_residue = res_r;

  // Pair stays reduced while the search runs.
  a_pair_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.per_step |-> (lo_r < m_r && hi_r < m_r))
    else $error("fmp_dp: pair left [0, m)");

  // The search never runs past 6m.
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.per_step |-> cnt_r < bound_r)
    else $error("fmp_dp: period search past bound");

  // Partial remainder stays below the period.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < cnt_r))
    else $error("fmp_dp: remainder out of range");

  // A result is only written into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_valid_r || out_ready))
    else $error("fmp_dp: output register overwritten");

endmodule

// ----- design/fibonacci_mod_pisano_unit.sv -----
// Top level of the Fibonacci-modulo-Pisano unit: F(n) mod m.
// Depends on fmp_pkg, fmp_if, fmp_ctrl and fmp_dp.
//
//   channel  dir  handshake            payload
//   in_ch    in   valid/ready          index_n[62:0], modulus[15:0]
//   out_ch   out  valid/ready          residue[15:0]
//
// Each transaction passes through idle (accept), setup, period search, the
// bit-serial reduction of n mod P, the recurrence with its count-exhausted
// check, and done, where P is the Pisano period of m (P <= 6m); a modulus
// below two goes from setup straight to done. The period search and the
// recurrence share one modular adder, one step a cycle.
// Reset (synchronous, rst_n low) returns the controller to idle and empties
// the output register; the other registers are not reset, and each accepted input reloads the working registers.
// in_ch.ready is high only when idle. A result waiting in the output register
// does not block the next input transaction; only a second finished result
// waits in the done state until out_ch.ready frees the register.
module fibonacci_mod_pisano_unit (
  input  logic         clk,
  input  logic         rst_n,
  fmp_in_if.sink       in_ch,
  fmp_out_if.source    out_ch
);

  fmp_pkg::cmd_t cmd;
  fmp_pkg::sts_t sts;

  // Sequencer: idle -> setup -> period search -> reduction -> recurrence -> done (setup -> done if m < 2)
  fmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and the output register
  fmp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_index_n  (in_ch.index_n),
    .in_modulus  (in_ch.modulus),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_residue (out_ch.residue)
  );

endmodule
